// ----- hw/rtl/pen_pkg.sv -----
// Shared types and constants for the percent-encoding normalizer.
// Depends on nothing; every other file in this block imports it.
package pen_pkg;

    // Most output characters that one input byte can cause.
    localparam int unsigned MAX_OUT = 5;

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_TILDE = 8'h7E;

    typedef logic [6:0] pen_char_t;
    typedef logic [2:0] pen_count_t;

    // What the escape parser is holding between input bytes.
    typedef enum logic [1:0] {
        HELD_NONE,
        HELD_PCT,
        HELD_DIGIT
    } pen_held_t;

    // One queued work record: the characters that one input byte produces.
    typedef struct packed {
        pen_char_t [MAX_OUT-1:0] chars;
        pen_count_t              count;
        logic                    last;
    } pen_entry_t;

endpackage

// ----- hw/rtl/pen_front.sv -----
// Front end of the normalizer: accepts input bytes, tracks escape state and
// builds one output record per byte that yields characters. Depends on pen_pkg.
module pen_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         in_byte,
    input  logic               in_last,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               q_full,
    output logic               q_push,
    output pen_pkg::pen_entry_t q_entry
);
    import pen_pkg::*;

    function automatic logic is_hex(input logic [7:0] c);
        is_hex = c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        if (c inside {[8'h30:8'h39]})
            hex_val = c[3:0];
        else
            hex_val = c[3:0] + 4'd9;
    endfunction

    function automatic logic is_unreserved(input logic [7:0] c);
        is_unreserved = c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
                                  CH_DASH, CH_DOT, CH_UNDER, CH_TILDE};
    endfunction

    function automatic pen_char_t hex_char(input logic [3:0] v);
        if (v < 4'd10)
            hex_char = {3'b011, v};
        else
            hex_char = 7'h37 + {3'b000, v};
    endfunction

    pen_held_t  held_reg, held_next, held_body;
    logic [7:0] digit_reg, digit_next, digit_body;

    logic       accept;
    logic       in_hex, in_pct, held_hex;
    logic [7:0] dec_val;

    pen_char_t [MAX_OUT-1:0] chars;
    pen_count_t              n_cnt;

    assign in_hex   = is_hex(in_byte);
    assign in_pct   = (in_byte == CH_PCT);
    assign held_hex = is_hex(digit_reg);
    assign dec_val  = {hex_val(digit_reg), hex_val(in_byte)};

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Next state: the held state after the byte itself, then the flush on last.
    always_comb
    begin
        digit_body = digit_reg;
        case (held_reg)
            HELD_PCT:
            begin
                if (in_hex)
                begin
                    held_body  = HELD_DIGIT;
                    digit_body = in_byte;
                end
                else
                begin
                    held_body = in_pct ? HELD_PCT : HELD_NONE;
                end
            end
            HELD_DIGIT:
            begin
                digit_body = '0;
                if (in_hex && held_hex)
                    held_body = HELD_NONE;
                else
                    held_body = in_pct ? HELD_PCT : HELD_NONE;
            end
            default:
            begin
                held_body = in_pct ? HELD_PCT : HELD_NONE;
            end
        endcase

        held_next  = held_body;
        digit_next = digit_body;
        if (in_last)
        begin
            held_next  = HELD_NONE;
            digit_next = '0;
        end
    end

    // Outputs: append the characters for this byte in order.
    always_comb
    begin
        logic do_fresh;
        chars    = '0;
        n_cnt    = '0;
        do_fresh = 1'b0;

        case (held_reg)
            HELD_PCT:
            begin
                if (!in_hex)
                begin
                    chars[n_cnt] = CH_PCT[6:0];
                    n_cnt        = n_cnt + 3'd1;
                    do_fresh     = 1'b1;
                end
            end
            HELD_DIGIT:
            begin
                if (in_hex && held_hex)
                begin
                    if (is_unreserved(dec_val))
                    begin
                        chars[n_cnt] = dec_val[6:0];
                        n_cnt        = n_cnt + 3'd1;
                    end
                    else
                    begin
                        chars[n_cnt] = CH_PCT[6:0];
                        n_cnt        = n_cnt + 3'd1;
                        chars[n_cnt] = hex_char(dec_val[7:4]);
                        n_cnt        = n_cnt + 3'd1;
                        chars[n_cnt] = hex_char(dec_val[3:0]);
                        n_cnt        = n_cnt + 3'd1;
                    end
                end
                else
                begin
                    chars[n_cnt] = CH_PCT[6:0];
                    n_cnt        = n_cnt + 3'd1;
                    chars[n_cnt] = digit_reg[6:0];
                    n_cnt        = n_cnt + 3'd1;
                    do_fresh     = 1'b1;
                end
            end
            default:
            begin
                do_fresh = 1'b1;
            end
        endcase

        // A fresh byte: a percent sign only starts an escape, so it adds nothing.
        if (do_fresh && !in_pct)
        begin
            if (in_byte[7])
            begin
                chars[n_cnt] = CH_PCT[6:0];
                n_cnt        = n_cnt + 3'd1;
                chars[n_cnt] = hex_char(in_byte[7:4]);
                n_cnt        = n_cnt + 3'd1;
                chars[n_cnt] = hex_char(in_byte[3:0]);
                n_cnt        = n_cnt + 3'd1;
            end
            else
            begin
                chars[n_cnt] = in_byte[6:0];
                n_cnt        = n_cnt + 3'd1;
            end
        end

        // End of string: anything still held goes out as plain characters.
        if (in_last && (held_body != HELD_NONE))
        begin
            chars[n_cnt] = CH_PCT[6:0];
            n_cnt        = n_cnt + 3'd1;
        end
        if (in_last && (held_body == HELD_DIGIT))
        begin
            chars[n_cnt] = digit_body[6:0];
            n_cnt        = n_cnt + 3'd1;
        end
    end

    assign q_entry.chars = chars;
    assign q_entry.count = n_cnt;
    assign q_entry.last  = in_last;
    assign q_push        = accept && (n_cnt != 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg  <= HELD_NONE;
            digit_reg <= '0;
        end
        else if (accept)
        begin
            held_reg  <= held_next;
            digit_reg <= digit_next;
        end
    end

endmodule

// ----- hw/rtl/pen_queue.sv -----
// Two-entry queue of output records between the front and back ends.
// Depends on pen_pkg.
module pen_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  pen_pkg::pen_entry_t push_entry,
    output logic               full,
    input  logic               pop,
    output pen_pkg::pen_entry_t head,
    output logic               empty
);
    import pen_pkg::*;

    pen_entry_t  slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

// ----- hw/rtl/pen_back.sv -----
// Back end of the normalizer: takes records from the queue and sends their
// characters out one per cycle while out_ready is high. Depends on pen_pkg.
module pen_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  pen_pkg::pen_entry_t q_head,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [6:0]         out_byte,
    output logic               out_last
);
    import pen_pkg::*;

    pen_entry_t cur_reg;
    pen_count_t idx_reg, idx_next;
    logic       busy_reg, busy_next;
    logic       out_fire, final_char, load;

    assign out_fire   = out_valid && out_ready;
    assign final_char = (idx_reg == (cur_reg.count - 3'd1));
    assign load       = !q_empty && (!busy_reg || (out_fire && final_char));
    assign q_pop      = load;

    assign out_valid = busy_reg;
    assign out_byte  = cur_reg.chars[idx_reg];
    assign out_last  = cur_reg.last && final_char;

    always_comb
    begin
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (load)
        begin
            idx_next  = '0;
            busy_next = 1'b1;
        end
        else if (out_fire)
        begin
            if (final_char)
                busy_next = 1'b0;
            else
                idx_next = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            cur_reg <= q_head;
    end

endmodule

// ----- hw/rtl/percent_encoding_normalizer.sv -----
// Percent-encoding normalizer for URL paths. Bytes of a path arrive one per
// transaction with in_last on the final byte; normalized ASCII leaves one
// character per transaction with out_last on the final character of the
// string. A valid escape (percent sign and two hex digits in either case)
// is decoded: unreserved octets (letters, digits, - . _ ~) come out plain,
// all others come out as a percent sign and two uppercase hex digits. Raw
// bytes of 128 and up are percent-encoded, other bytes pass through, and a
// broken or cut-off escape comes out as the literal characters it held.
// Timing: the output port sends one character per cycle while out_ready is
// high, so an input byte occupies the output while its characters go out,
// from zero (a byte that is only held as part of an escape) to five. Ordinary
// bytes stream at one per cycle when the output does not stall. The front end
// classifies a byte in the cycle it is accepted and pushes a record into a
// two-entry queue; the back end holds one more record and serializes it, so
// input keeps flowing while output is stalled until both queue slots are
// full. A byte's characters pass through a queue slot and then the back
// end's record register before they reach the output.
// Depends on pen_pkg, pen_front, pen_queue and pen_back.
module percent_encoding_normalizer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       in_valid,
    output logic       in_ready,
    output logic [6:0] out_byte,
    output logic       out_last,
    output logic       out_valid,
    input  logic       out_ready
);
    import pen_pkg::*;

    // Records travel from the front end through the queue to the back end.
    pen_entry_t push_entry;
    pen_entry_t head_entry;
    logic       q_push;
    logic       q_full;
    logic       q_pop;
    logic       q_empty;

    pen_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (push_entry)
    );

    pen_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head       (head_entry),
        .empty      (q_empty)
    );

    pen_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (head_entry),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

endmodule

// ----- tb/percent_encoding_normalizer_checker.sv -----
// Checker for the percent-encoding normalizer: watches both channels, predicts the
// normalized characters of every accepted input byte and compares them in order.
// Depends on pen_pkg for the character type, the held-state enum and the character codes.
module percent_encoding_normalizer_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [6:0]  out_byte,
    input  logic        out_last,
    input  logic        out_valid,
    input  logic        out_ready,
    output int unsigned mismatches,
    output int unsigned outstanding
);
    import pen_pkg::*;

    typedef struct packed {
        pen_char_t ch;
        logic      last;
    } norm_char_t;

    norm_char_t  expected_chars[$];
    pen_held_t   held_state;
    logic [7:0]  held_hex;
    int unsigned mismatch_count;

    assign mismatches = mismatch_count;

    function automatic int hex_value(logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 32'h30;
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 32'h57;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 32'h37;
        return -1;
    endfunction

    function automatic bit is_unreserved(logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return 1'b1;
        if (c >= 8'h41 && c <= 8'h5A) return 1'b1;
        if (c >= 8'h61 && c <= 8'h7A) return 1'b1;
        return c == CH_DASH || c == CH_DOT || c == CH_UNDER || c == CH_TILDE;
    endfunction

    function automatic pen_char_t upper_hex(logic [3:0] nibble);
        return (nibble < 4'd10) ? 7'h30 + {3'b000, nibble} : 7'h37 + {3'b000, nibble};
    endfunction

    task automatic push_char(pen_char_t c);
        norm_char_t entry;
        entry.ch   = c;
        entry.last = 1'b0;
        expected_chars.push_back(entry);
    endtask

    task automatic push_escaped(logic [7:0] octet);
        push_char(CH_PCT[6:0]);
        push_char(upper_hex(octet[7:4]));
        push_char(upper_hex(octet[3:0]));
    endtask

    // A byte seen with nothing held: a percent sign opens an escape.
    task automatic take_plain(logic [7:0] c);
        if (c == CH_PCT)
            held_state = HELD_PCT;
        else if (c[7])
            push_escaped(c);
        else
            push_char(c[6:0]);
    endtask

    task automatic normalize_byte(logic [7:0] c, logic ends_path);
        int          first_new;
        int          lo;
        int          hi;
        logic [7:0]  octet;
        norm_char_t  tail;
        first_new = expected_chars.size();
        case (held_state)
            HELD_PCT:
            begin
                if (hex_value(c) >= 0)
                begin
                    held_hex   = c;
                    held_state = HELD_DIGIT;
                end
                else
                begin
                    push_char(CH_PCT[6:0]);
                    held_state = HELD_NONE;
                    take_plain(c);
                end
            end
            HELD_DIGIT:
            begin
                lo = hex_value(c);
                hi = hex_value(held_hex);
                if (lo >= 0 && hi >= 0)
                begin
                    octet      = {hi[3:0], lo[3:0]};
                    held_state = HELD_NONE;
                    held_hex   = '0;
                    if (is_unreserved(octet))
                        push_char(octet[6:0]);
                    else
                        push_escaped(octet);
                end
                else
                begin
                    push_char(CH_PCT[6:0]);
                    push_char(held_hex[6:0]);
                    held_state = HELD_NONE;
                    held_hex   = '0;
                    take_plain(c);
                end
            end
            default:
            begin
                held_state = HELD_NONE;
                take_plain(c);
            end
        endcase
        // End of path: whatever is still held comes out literally.
        if (ends_path)
        begin
            if (held_state != HELD_NONE) push_char(CH_PCT[6:0]);
            if (held_state == HELD_DIGIT) push_char(held_hex[6:0]);
            held_state = HELD_NONE;
            held_hex   = '0;
            if (expected_chars.size() > first_new)
            begin
                tail      = expected_chars.pop_back();
                tail.last = 1'b1;
                expected_chars.push_back(tail);
            end
        end
    endtask

    task automatic note_mismatch(string field, int unsigned want, int unsigned got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s mismatch: expected 0x%02h, got 0x%02h at %0t", field, want, got, $time);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        norm_char_t head;
        if (!rst_n)
        begin
            expected_chars.delete();
            held_state  = HELD_NONE;
            held_hex    = '0;
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected output 0x%02h (last %b) at %0t",
                                 out_byte, out_last, $time);
                end
                else
                begin
                    head = expected_chars.pop_front();
                    if (out_byte !== head.ch)
                        note_mismatch("out_byte", 32'(head.ch), 32'(out_byte));
                    if (out_last !== head.last)
                        note_mismatch("out_last", 32'(head.last), 32'(out_last));
                end
            end
            if (in_valid && in_ready)
                normalize_byte(in_byte, in_last);
            outstanding <= expected_chars.size();
        end
    end

endmodule

// ----- tb/percent_encoding_normalizer_tb.sv -----
// Top of the percent-encoding normalizer testbench: clock, reset, path stimulus and
// a stalling sink. Depends on pen_pkg, the normalizer RTL and the normalizer checker.
module percent_encoding_normalizer_tb;
    import pen_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 170;
    // Watchdog limit on the length of the whole run, set with a wide margin.
    localparam int unsigned CYCLE_LIMIT  = 200000;
    // Margin after the final drain, for anything that trails the last result.
    localparam int unsigned TAIL_CYCLES  = 20;
    localparam string       UNRESERVED   =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-._~";

    typedef logic [7:0] octet_q_t[$];

    logic        clk;
    logic        rst_n;
    logic [7:0]  in_byte;
    logic        in_last;
    logic        in_valid;
    logic        in_ready;
    logic [6:0]  out_byte;
    logic        out_last;
    logic        out_valid;
    logic        out_ready;
    int unsigned error_count;
    int unsigned chars_outstanding;
    int unsigned cycle_count;
    bit          sender_calm;

    percent_encoding_normalizer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_byte  (out_byte),
        .out_last  (out_last),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

    // The checker sees the same pins as the block and keeps the whole prediction;
    // this module only makes traffic and reads back the mismatch and outstanding counts.
    percent_encoding_normalizer_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_byte     (in_byte),
        .in_last     (in_last),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .out_byte    (out_byte),
        .out_last    (out_last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .mismatches  (error_count),
        .outstanding (chars_outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Idle lengths: mostly none or short, now and then a long one. A calm phase
    // turns idling off entirely so the block also sees back-to-back traffic.
    function automatic int unsigned pick_gap(bit calm);
        int unsigned roll;
        if (calm) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ASCII hex digit for a nibble; letters in lower or upper case.
    function automatic logic [7:0] hex_char(logic [3:0] nibble, bit lower);
        if (nibble < 4'd10) return 8'h30 + {4'h0, nibble};
        return (lower ? 8'h57 : 8'h37) + {4'h0, nibble};
    endfunction

    function automatic bit is_hex_char(logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (is_hex_char(c));
        return c;
    endfunction

    // One input transaction. Valid is only lowered when a gap is taken, so a
    // back-to-back transaction never gets two assignments in the same step.
    task automatic send_item(logic [7:0] value, logic ends_path);
        int unsigned gap;
        gap = pick_gap(sender_calm);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= value;
        in_last  <= ends_path;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_path(octet_q_t path);
        foreach (path[i])
            send_item(path[i], i == path.size() - 1);
    endtask

    // Hold off the sender until every predicted character has left the block.
    // The extra edge lets the checker's count take in the last accepted byte.
    task automatic wait_for_empty();
        in_valid <= 1'b0;
        @(posedge clk);
        while (chars_outstanding != 0) @(posedge clk);
    endtask

    // A random path built from tokens: plain unreserved characters, other ASCII,
    // raw high bytes, well-formed escapes in either case, malformed escapes and
    // bare or half escapes. A tenth of the paths are raw noise instead.
    task automatic build_path(output octet_q_t path);
        int unsigned kind;
        logic [7:0]  octet;
        bit          lower;
        path = {};
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 6)) path.push_back(8'($urandom_range(1, 255)));
            return;
        end
        repeat ($urandom_range(1, 8))
        begin
            kind  = $urandom_range(0, 99);
            lower = 1'($urandom_range(0, 1));
            if (kind < 25)
                path.push_back(UNRESERVED[$urandom_range(0, UNRESERVED.len() - 1)]);
            else if (kind < 45)
                path.push_back(8'($urandom_range(1, 127)));
            else if (kind < 60)
                path.push_back(8'($urandom_range(128, 255)));
            else if (kind < 85)
            begin
                // Half of the escapes stay in printable ASCII so that many decode
                // to unreserved characters; the rest cover every octet.
                octet = lower ? 8'($urandom_range(0, 255)) : 8'($urandom_range(8'h20, 8'h7E));
                path.push_back(CH_PCT);
                path.push_back(hex_char(octet[7:4], 1'($urandom_range(0, 1))));
                path.push_back(hex_char(octet[3:0], 1'($urandom_range(0, 1))));
            end
            else if (kind < 95)
            begin
                path.push_back(CH_PCT);
                if ($urandom_range(0, 1)) path.push_back(hex_char(4'($urandom), lower));
                path.push_back(non_hex_byte());
            end
            else
            begin
                path.push_back(CH_PCT);
                if ($urandom_range(0, 1)) path.push_back(hex_char(4'($urandom), lower));
            end
        end
    endtask

    // The sink stalls at random with its own calm phases, independent of the sender.
    initial
    begin
        int unsigned stall;
        bit          sink_calm;
        stall     = 0;
        sink_calm = 1'b0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 149) == 0) sink_calm = !sink_calm;
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!sink_calm && $urandom_range(0, 3) == 0) stall = pick_gap(1'b0);
            end
        end
    end

    // Watchdog: a hang anywhere ends the run here.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin
        octet_q_t    path;
        int unsigned sent;
        bit          paused;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_byte     = 8'h01;
        in_last     = 1'b0;
        sender_calm = 1'b0;
        paused      = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed paths. First: a plain letter, an escape that decodes to a letter,
        // a lower-case escape of a reserved octet that comes back upper case, an
        // escaped tilde, the extremes of raw high bytes and the top ASCII byte.
        path = '{8'h61, CH_PCT, 8'h34, 8'h31, CH_PCT, 8'h32, 8'h66, CH_PCT, 8'h37, 8'h45,
                 8'hFF, 8'h80, 8'h7F};
        send_path(path);
        // Malformed escapes with and without a held digit, a percent sign that
        // breaks one escape and opens the next, and an escape cut off by the end.
        path = '{CH_PCT, 8'h47, CH_PCT, 8'h34, 8'h5A, CH_PCT, CH_PCT, 8'h34, 8'h31,
                 CH_PCT, 8'h34};
        send_path(path);
        // A lone percent sign as the whole path.
        path = '{CH_PCT};
        send_path(path);
        // Percent, digit, then a high byte at the end: five characters from one byte.
        path = '{CH_PCT, 8'h61, 8'h90};
        send_path(path);
        // The byte 0x01 as a path of its own.
        path = '{8'h01};
        send_path(path);
        wait_for_empty();

        // Random paths, with one full pause of the sender halfway through.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            sender_calm = ($urandom_range(0, 4) == 0);
            build_path(path);
            send_path(path);
            sent += path.size();
            if (!paused && sent >= RANDOM_ITEMS / 2)
            begin
                wait_for_empty();
                paused = 1'b1;
            end
        end

        wait_for_empty();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/pen_pkg.sv
hw/rtl/pen_front.sv
hw/rtl/pen_queue.sv
hw/rtl/pen_back.sv
hw/rtl/percent_encoding_normalizer.sv
tb/percent_encoding_normalizer_checker.sv
tb/percent_encoding_normalizer_tb.sv
